>>> design/trer_pkg.sv
// package for the triangle edge rasterizer
// shared constants, request and register codes, controller/datapath structs
// no dependencies
`default_nettype none

package trer_pkg;

  // default sizes of the frame store and vertex coordinates
  localparam int DEF_MAX_WIDTH  = 128;
  localparam int DEF_MAX_HEIGHT = 32;
  localparam int DEF_COORD_BITS = 17;

  // fixed field widths
  localparam int REQ_BITS      = 2;
  localparam int COL_BITS      = 7;
  localparam int ROW_BITS      = 5;
  localparam int SW_BITS       = 8;
  localparam int SH_BITS       = 6;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 8;

  // request kinds
  localparam logic [REQ_BITS-1:0] REQ_CLEAR = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_DRAW  = 2'd1;
  localparam logic [REQ_BITS-1:0] REQ_READ  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 1'd1;

  // register reset values
  localparam logic [SW_BITS-1:0] RESET_WIDTH  = 8'd100;
  localparam logic [SH_BITS-1:0] RESET_HEIGHT = 6'd30;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic setup;
    logic mul;
    logic row_rd;
    logic row_ld;
    logic scan;
    logic row_wr;
    logic rd_pix;
    logic clr;
    logic finish;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic mul_last;
    logic box_empty;
    logic scan_last;
    logic row_last;
  } sts_t;

endpackage

`default_nettype wire

>>> design/triangle_edge_rasterizer_core.sv
// triangle edge rasterizer top level; uses trer_pkg, trer_ctrl, trer_datapath
// one item at a time: busy from accept until done, no new request is taken while busy
// a read looks up one stored row, an unused kind goes straight to finish, a clear sweeps
// every store row, and a draw sets up the clipped box, then per row reads, scans and
// writes back the row; the pixel scan covers one pixel per cycle
// reset runs a clearing pass over all MAX_HEIGHT rows with busy high; receiver cannot stall
`default_nettype none

module triangle_edge_rasterizer_core #(
  parameter int MAX_WIDTH  = trer_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = trer_pkg::DEF_MAX_HEIGHT,
  parameter int COORD_BITS = trer_pkg::DEF_COORD_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // request channel
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [trer_pkg::REQ_BITS-1:0]       req_type,
  input  wire logic signed [COORD_BITS-1:0]        vert0_x,
  input  wire logic signed [COORD_BITS-1:0]        vert0_y,
  input  wire logic signed [COORD_BITS-1:0]        vert1_x,
  input  wire logic signed [COORD_BITS-1:0]        vert1_y,
  input  wire logic signed [COORD_BITS-1:0]        vert2_x,
  input  wire logic signed [COORD_BITS-1:0]        vert2_y,
  input  wire logic [trer_pkg::COL_BITS-1:0]       read_col,
  input  wire logic [trer_pkg::ROW_BITS-1:0]       read_row,
  // result channel
  output logic                                     done,
  output logic [trer_pkg::REQ_BITS-1:0]            done_kind,
  output logic                                     pixel_covered,
  // configuration write channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [trer_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [trer_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  trer_pkg::cmd_t cmd;
  trer_pkg::sts_t sts;

  // config writes are always taken; the user must send them only while idle, not enforced here
  assign cfg_ready = 1'b1;

  // sequencing: clear sweep, box setup with a shared multiplier, row scan
  trer_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .busy     (busy),
    .cmd      (cmd),
    .sts      (sts)
  );

  // edge functions start at the box corner and then step by constant deltas,
  // each row is read from the store, marked in a buffer and written back
  trer_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .req_type      (req_type),
    .vert0_x       (vert0_x),
    .vert0_y       (vert0_y),
    .vert1_x       (vert1_x),
    .vert1_y       (vert1_y),
    .vert2_x       (vert2_x),
    .vert2_y       (vert2_y),
    .read_col      (read_col),
    .read_row      (read_row),
    .cfg_we        (cfg_valid & cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .done          (done),
    .done_kind     (done_kind),
    .pixel_covered (pixel_covered)
  );

endmodule

`default_nettype wire

>>> design/trer_store.sv
// coverage frame store, one row of pixel bits per entry
// one write port, one read port with registered read data; no dependencies
`default_nettype none

module trer_store #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 32
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [$clog2(MAX_HEIGHT)-1:0] waddr,
  input  wire logic [MAX_WIDTH-1:0]          wdata,
  input  wire logic [$clog2(MAX_HEIGHT)-1:0] raddr,
  output logic      [MAX_WIDTH-1:0]          rdata
);

  logic [MAX_WIDTH-1:0] mem [MAX_HEIGHT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> design/trer_datapath.sv
// datapath: config registers, bounding box, edge function setup and stepping,
// row buffer and result registers; uses trer_pkg and trer_store
`default_nettype none

module trer_datapath #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 32,
  parameter int COORD_BITS = 17
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire trer_pkg::cmd_t                       cmd,
  output trer_pkg::sts_t                            sts,
  input  wire logic [trer_pkg::REQ_BITS-1:0]        req_type,
  input  wire logic signed [COORD_BITS-1:0]         vert0_x,
  input  wire logic signed [COORD_BITS-1:0]         vert0_y,
  input  wire logic signed [COORD_BITS-1:0]         vert1_x,
  input  wire logic signed [COORD_BITS-1:0]         vert1_y,
  input  wire logic signed [COORD_BITS-1:0]         vert2_x,
  input  wire logic signed [COORD_BITS-1:0]         vert2_y,
  input  wire logic [trer_pkg::COL_BITS-1:0]        read_col,
  input  wire logic [trer_pkg::ROW_BITS-1:0]        read_row,
  input  wire logic                                 cfg_we,
  input  wire logic [trer_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [trer_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output logic                                      done,
  output logic [trer_pkg::REQ_BITS-1:0]             done_kind,
  output logic                                      pixel_covered
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int PB = (XW > YW) ? XW : YW;
  localparam int CW = (COORD_BITS + 1 > PB + 2) ? COORD_BITS + 1 : PB + 2;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int EW = PW + 2;

  localparam logic signed [CW-1:0] ZERO_C = '0;
  localparam logic signed [CW-1:0] ONE_C  = 1;
  localparam logic signed [DW-1:0] ONE_D  = 1;
  localparam logic [2:0]           MUL_LAST = 3'd6;

  // configuration
  logic [trer_pkg::SW_BITS-1:0] screen_width;
  logic [trer_pkg::SH_BITS-1:0] screen_height;

  // latched request
  logic [trer_pkg::REQ_BITS-1:0] kind_q;
  logic signed [COORD_BITS-1:0]  vx_q [3];
  logic signed [COORD_BITS-1:0]  vy_q [3];
  logic [trer_pkg::COL_BITS-1:0] rcol_q;
  logic [trer_pkg::ROW_BITS-1:0] rrow_q;

  // box and edge setup
  logic signed [CW-1:0] lo_x, hi_x, lo_y, hi_y;
  logic signed [DW-1:0] a_q [3];
  logic signed [DW-1:0] b_q [3];
  logic [2:0]           mt;
  logic signed [PW-1:0] prod;
  logic signed [EW-1:0] e_row [3];
  logic signed [EW-1:0] e_cur [3];

  // scan
  logic [XW-1:0]        px;
  logic [YW-1:0]        py;
  logic [YW-1:0]        clr_row;
  logic [MAX_WIDTH-1:0] row_bits;

  // store interface
  logic                 st_we;
  logic [YW-1:0]        st_waddr;
  logic [MAX_WIDTH-1:0] st_wdata;
  logic [YW-1:0]        st_raddr;
  logic [MAX_WIDTH-1:0] st_rdata;

  // combinational helpers
  logic [31:0]          aw32, ah32, col32, row32;
  logic signed [CW-1:0] awm1, ahm1;
  logic signed [CW-1:0] ex [3];
  logic signed [CW-1:0] ey [3];
  logic signed [CW-1:0] dvx [3];
  logic signed [CW-1:0] dvy [3];
  logic signed [CW-1:0] min_x, max_x, min_y, max_y;
  logic signed [DW-1:0] cx0, cy0, op1, op2;
  logic                 all_nonneg, all_nonpos, covered, in_screen;

  // active screen, saturated to the store size
  always_comb begin
    aw32 = (32'(screen_width) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : 32'(screen_width);
    ah32 = (32'(screen_height) > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : 32'(screen_height);
    awm1 = signed'(aw32[CW-1:0]) - ONE_C;
    ahm1 = signed'(ah32[CW-1:0]) - ONE_C;
    col32 = 32'(rcol_q);
    row32 = 32'(rrow_q);
    in_screen = (col32 < aw32) && (row32 < ah32);
  end

  // vertices extended and doubled
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ex[i]  = CW'(vx_q[i]);
      ey[i]  = CW'(vy_q[i]);
      dvx[i] = ex[i] <<< 1;
      dvy[i] = ey[i] <<< 1;
    end
    min_x = (ex[0] < ex[1]) ? ex[0] : ex[1];
    min_x = (min_x < ex[2]) ? min_x : ex[2];
    max_x = (ex[0] > ex[1]) ? ex[0] : ex[1];
    max_x = (max_x > ex[2]) ? max_x : ex[2];
    min_y = (ey[0] < ey[1]) ? ey[0] : ey[1];
    min_y = (min_y < ey[2]) ? min_y : ey[2];
    max_y = (ey[0] > ey[1]) ? ey[0] : ey[1];
    max_y = (max_y > ey[2]) ? max_y : ey[2];
  end

  // multiplier operands, one partial term per step
  always_comb begin
    cx0 = (DW'(lo_x) <<< 1) + ONE_D;
    cy0 = (DW'(lo_y) <<< 1) + ONE_D;
    unique case (mt)
      3'd0: begin op1 = cx0 - DW'(dvx[1]); op2 = a_q[0]; end
      3'd1: begin op1 = cy0 - DW'(dvy[1]); op2 = b_q[0]; end
      3'd2: begin op1 = cx0 - DW'(dvx[2]); op2 = a_q[1]; end
      3'd3: begin op1 = cy0 - DW'(dvy[2]); op2 = b_q[1]; end
      3'd4: begin op1 = cx0 - DW'(dvx[0]); op2 = a_q[2]; end
      3'd5: begin op1 = cy0 - DW'(dvy[0]); op2 = b_q[2]; end
      default: begin op1 = '0; op2 = '0; end
    endcase
  end

  // common-sign test, both windings
  always_comb begin
    all_nonneg = 1'b1;
    all_nonpos = 1'b1;
    for (int i = 0; i < 3; i++) begin
      all_nonneg = all_nonneg & ~e_cur[i][EW-1];
      all_nonpos = all_nonpos & (e_cur[i][EW-1] | (e_cur[i] == '0));
    end
    covered = all_nonneg | all_nonpos;
  end

  always_comb begin
    sts.clr_last  = (32'(clr_row) == 32'(MAX_HEIGHT - 1));
    sts.mul_last  = (mt == MUL_LAST);
    sts.box_empty = (lo_x > hi_x) || (lo_y > hi_y);
    sts.scan_last = (px == hi_x[XW-1:0]);
    sts.row_last  = (py == hi_y[YW-1:0]);
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= trer_pkg::RESET_WIDTH;
      screen_height <= trer_pkg::RESET_HEIGHT;
    end else if (cfg_we) begin
      if (cfg_index == trer_pkg::CFG_WIDTH) begin
        screen_width <= cfg_data;
      end
      if (cfg_index == trer_pkg::CFG_HEIGHT) begin
        screen_height <= cfg_data[trer_pkg::SH_BITS-1:0];
      end
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q  <= req_type;
      vx_q[0] <= vert0_x;
      vy_q[0] <= vert0_y;
      vx_q[1] <= vert1_x;
      vy_q[1] <= vert1_y;
      vx_q[2] <= vert2_x;
      vy_q[2] <= vert2_y;
      rcol_q  <= read_col;
      rrow_q  <= read_row;
    end
  end

  // box clip and edge deltas
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      lo_x <= (min_x < ZERO_C) ? ZERO_C : min_x;
      lo_y <= (min_y < ZERO_C) ? ZERO_C : min_y;
      hi_x <= (max_x > awm1) ? awm1 : max_x;
      hi_y <= (max_y > ahm1) ? ahm1 : max_y;
      a_q[0] <= DW'(dvy[2]) - DW'(dvy[1]);
      b_q[0] <= DW'(dvx[2]) - DW'(dvx[1]);
      a_q[1] <= DW'(dvy[0]) - DW'(dvy[2]);
      b_q[1] <= DW'(dvx[0]) - DW'(dvx[2]);
      a_q[2] <= DW'(dvy[1]) - DW'(dvy[0]);
      b_q[2] <= DW'(dvx[1]) - DW'(dvx[0]);
    end
  end

  // shared multiplier sequence, product registered then accumulated
  always_ff @(posedge clk) begin
    if (rst) begin
      mt <= '0;
    end else if (cmd.setup) begin
      mt <= '0;
    end else if (cmd.mul && !sts.mul_last) begin
      mt <= mt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= op1 * op2;
      py   <= lo_y[YW-1:0];
      unique case (mt)
        3'd1: e_row[0] <= EW'(prod);
        3'd2: e_row[0] <= e_row[0] - EW'(prod);
        3'd3: e_row[1] <= EW'(prod);
        3'd4: e_row[1] <= e_row[1] - EW'(prod);
        3'd5: e_row[2] <= EW'(prod);
        3'd6: e_row[2] <= e_row[2] - EW'(prod);
        default: ;
      endcase
    end else if (cmd.row_wr) begin
      py <= py + YW'(1);
      for (int i = 0; i < 3; i++) begin
        e_row[i] <= e_row[i] - (EW'(b_q[i]) <<< 1);
      end
    end
  end

  // pixel stepping across a row
  always_ff @(posedge clk) begin
    if (cmd.row_rd) begin
      px <= lo_x[XW-1:0];
      for (int i = 0; i < 3; i++) begin
        e_cur[i] <= e_row[i];
      end
    end else if (cmd.scan) begin
      px <= px + XW'(1);
      for (int i = 0; i < 3; i++) begin
        e_cur[i] <= e_cur[i] + (EW'(a_q[i]) <<< 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.row_ld) begin
      row_bits <= st_rdata;
    end else if (cmd.scan && covered) begin
      row_bits[px] <= 1'b1;
    end
  end

  // clearing sweep row counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_row <= '0;
    end else if (cmd.clr) begin
      clr_row <= sts.clr_last ? '0 : clr_row + YW'(1);
    end
  end

  always_comb begin
    st_we    = cmd.clr | cmd.row_wr;
    st_waddr = cmd.clr ? clr_row : py;
    st_wdata = cmd.clr ? '0 : row_bits;
    st_raddr = cmd.rd_pix ? row32[YW-1:0] : py;
  end

  trer_store #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      done_kind     <= kind_q;
      pixel_covered <= (kind_q == trer_pkg::REQ_READ) && in_screen && st_rdata[col32[XW-1:0]];
    end
  end

endmodule

`default_nettype wire

>>> design/trer_ctrl.sv
// controller state machine for the triangle edge rasterizer
// sequences clear, draw and read work; uses trer_pkg
`default_nettype none

module trer_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [trer_pkg::REQ_BITS-1:0] req_type,
  output logic                               busy,
  output trer_pkg::cmd_t                     cmd,
  input  wire trer_pkg::sts_t                sts
);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_CLEAR   = 10'b00_0000_0010,
    S_SETUP   = 10'b00_0000_0100,
    S_MUL     = 10'b00_0000_1000,
    S_ROW_RD  = 10'b00_0001_0000,
    S_ROW_LD  = 10'b00_0010_0000,
    S_SCAN    = 10'b00_0100_0000,
    S_ROW_WR  = 10'b00_1000_0000,
    S_READ_RD = 10'b01_0000_0000,
    S_FINISH  = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;
  logic   from_req, from_req_next;
  logic   accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);

  always_comb begin
    state_next    = state;
    from_req_next = from_req;
    cmd           = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load      = 1'b1;
          from_req_next = 1'b1;
          unique case (req_type)
            trer_pkg::REQ_CLEAR: state_next = S_CLEAR;
            trer_pkg::REQ_DRAW:  state_next = S_SETUP;
            trer_pkg::REQ_READ:  state_next = S_READ_RD;
            default:             state_next = S_FINISH;
          endcase
        end
      end
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_next = from_req ? S_FINISH : S_IDLE;
        end
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        if (sts.mul_last) begin
          state_next = sts.box_empty ? S_FINISH : S_ROW_RD;
        end
      end
      S_ROW_RD: begin
        cmd.row_rd = 1'b1;
        state_next = S_ROW_LD;
      end
      S_ROW_LD: begin
        cmd.row_ld = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_next = S_ROW_WR;
        end
      end
      S_ROW_WR: begin
        cmd.row_wr = 1'b1;
        state_next = sts.row_last ? S_FINISH : S_ROW_RD;
      end
      S_READ_RD: begin
        cmd.rd_pix = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      from_req <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        from_req <= from_req_next;
      end
    end
  end

endmodule

`default_nettype wire
